>>> src/julia_escape_audio_sample_assert.svh
// Assertion macros shared by the julia escape audio sample RTL.
`ifndef JULIA_ESCAPE_AUDIO_SAMPLE_ASSERT_SVH
`define JULIA_ESCAPE_AUDIO_SAMPLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define JESC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define JESC_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define JESC_ASSERT(label, clk, rst, prop, msg)
`define JESC_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

>>> src/jesc_pkg.sv
// Package: constants, types, sine table and helpers of the julia escape block.
`timescale 1ns / 1ps
package jesc_pkg;

   localparam int ITERATION_LIMIT      = 256;
   localparam int SINE_TABLE_ADDR_BITS = 10;
   localparam int COORD_FRAC_BITS      = 28;

   localparam int SAMPLE_NUMBER_W = 48;
   localparam int AUDIO_W         = 16;
   localparam int COUNT_W         = 9;
   localparam int COORD_W         = 32;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 32;
   localparam int ITER_W          = $clog2(ITERATION_LIMIT + 1);
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] ZOOM_STEP  = 32'd354;
   localparam logic [31:0] ORBIT_STEP = 32'd89;
   localparam logic [31:0] TONE_STEP  = 32'd2447909;

   // sine table
   localparam int TABLE_QUARTER = 1 << (SINE_TABLE_ADDR_BITS - 2);
   localparam int QTR_W         = SINE_TABLE_ADDR_BITS - 2;
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] HORNER_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   // fixed-point constants
   localparam logic signed [63:0] C21 = ((64'sd21 <<< COORD_FRAC_BITS) + 64'sd5) / 64'sd10;
   localparam logic signed [63:0] C19 = ((64'sd19 <<< COORD_FRAC_BITS) + 64'sd5) / 64'sd10;
   localparam logic signed [63:0] ONE_F = 64'sd1 <<< COORD_FRAC_BITS;
   localparam int ORBIT_SHIFT = 31 - COORD_FRAC_BITS;
   localparam int DIV_SHIFT   = 2 * COORD_FRAC_BITS - 30;
   localparam int NUM_W       = 2 * COORD_FRAC_BITS + 2;
   localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
   localparam int ESCAPE_BIT  = 2 * COORD_FRAC_BITS + 2;

   // audio mapping, kept as running quotient and remainder of iter*56000 by the limit
   localparam int AUDIO_SPAN   = 56000;
   localparam int AUDIO_OFFSET = 28000;
   localparam int AUDIO_STEP_Q = AUDIO_SPAN / ITERATION_LIMIT;
   localparam int AUDIO_STEP_R = AUDIO_SPAN % ITERATION_LIMIT;
   localparam int REM_W        = $clog2(ITERATION_LIMIT);

   typedef logic [31:0] qtab_type [TABLE_QUARTER];

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_C_REAL = 1'b0,
      CSR_C_IMAG = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] zr;
      logic signed [COORD_W-1:0] zi;
   } coord_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [3:0] {
      F_IDLE,
      F_LOOK,
      F_ZMUL,
      F_ZOOM,
      F_DSTR,
      F_DWR,
      F_DSTI,
      F_DWI,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_RUN,
      B_DONE
   } back_state_type;

   function automatic logic [63:0] quarter_sine(input int unsigned j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      x  = (HALF_PI_Q30 * 64'(j)) / 64'(TABLE_QUARTER);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int k = 0; k < 6; k++) begin
         t = Q30_ONE - (((x2 * t) >> 30) / HORNER_DIV[k]);
      end
      return (x * t) >> 30;
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type tab;
      for (int j = 0; j < TABLE_QUARTER; j++) begin
         tab[j] = 32'(quarter_sine(j));
      end
      return tab;
   endfunction

   localparam qtab_type QTAB = build_qtab();
   localparam logic [31:0] QMAX = 32'(quarter_sine(TABLE_QUARTER));

   // full-turn lookup from the quarter table
   function automatic logic signed [31:0] sine_lookup(
      input logic [SINE_TABLE_ADDR_BITS-1:0] addr
   );
      logic [1:0]       quad;
      logic [QTR_W-1:0] j;
      logic [QTR_W-1:0] jm;
      logic [31:0]      mag;
      quad = addr[SINE_TABLE_ADDR_BITS-1 -: 2];
      j    = addr[QTR_W-1:0];
      jm   = -j;
      if (quad[0]) begin
         mag = (j == '0) ? QMAX : QTAB[jm];
      end else begin
         mag = QTAB[j];
      end
      return quad[1] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

>>> src/jesc_if.sv
// Channel interfaces: sample request, audio response and register write port.
`timescale 1ns / 1ps
interface jesc_req_if;
   logic                                valid;
   logic                                ready;
   logic [jesc_pkg::SAMPLE_NUMBER_W-1:0] sample_number;
   modport source (output valid, output sample_number, input ready);
   modport sink (input valid, input sample_number, output ready);
endinterface

interface jesc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [jesc_pkg::AUDIO_W-1:0] audio_sample;
   logic [jesc_pkg::COUNT_W-1:0]        iteration_count;
   modport source (output valid, output audio_sample, output iteration_count, input ready);
   modport sink (input valid, input audio_sample, input iteration_count, output ready);
endinterface

interface jesc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [jesc_pkg::CSR_INDEX_W-1:0] index;
   logic [jesc_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/jesc_div.sv
// Restoring divider, one quotient bit per cycle, signed by positive, truncating.
`timescale 1ns / 1ps
module jesc_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [jesc_pkg::NUM_W-1:0]    dividend,
   input  logic [31:0]                          divisor,
   output jesc_pkg::div_stat_type               stat,
   output logic signed [jesc_pkg::NUM_W-1:0]    quotient
);
   import jesc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     mag_ff, mag_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [32:0]          trial;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, mag_ff[NUM_W-1]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(NUM_W);
         neg_in  = dividend[NUM_W-1];
         mag_in  = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
         mag_in = {mag_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

endmodule

>>> src/jesc_front.sv
// Front end: takes a sample number, looks up sines, forms zoom and the start point.
`timescale 1ns / 1ps
`include "julia_escape_audio_sample_assert.svh"
module jesc_front (
   input  logic                clock,
   input  logic                reset,
   jesc_req_if.sink            req,
   output logic                push,
   output jesc_pkg::coord_type push_data,
   input  logic                full
);
   import jesc_pkg::*;

   localparam int A = SINE_TABLE_ADDR_BITS;

   front_state_type state_ff, state_in;
   logic [2:0]         look_ff, look_in;
   logic [A-1:0]       az_ff, az_in, ao_ff, ao_in, at_ff, at_in;
   logic signed [31:0] sinz_ff, sinz_in, coso_ff, coso_in, sino_ff, sino_in;
   logic signed [31:0] sint_ff, sint_in, cost_ff, cost_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [31:0]        zoom_ff, zoom_in;
   coord_type          pt_ff, pt_in;
   logic [31:0]        n32;
   logic [31:0]        ph_z, ph_o, ph_t;
   logic [A-1:0]       look_addr;
   logic signed [31:0] look_val;
   logic signed [63:0] zoom_sum;
   logic               div_start;
   logic signed [NUM_W-1:0] div_num;
   logic signed [NUM_W-1:0] div_quo;
   div_stat_type       div_stat;

   jesc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (zoom_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      look_ff <= look_in;
      az_ff   <= az_in;
      ao_ff   <= ao_in;
      at_ff   <= at_in;
      sinz_ff <= sinz_in;
      coso_ff <= coso_in;
      sino_ff <= sino_in;
      sint_ff <= sint_in;
      cost_ff <= cost_in;
      prod_ff <= prod_in;
      zoom_ff <= zoom_in;
      pt_ff   <= pt_in;
   end

   always_comb begin
      n32  = req.sample_number[31:0];
      ph_z = n32 * ZOOM_STEP;
      ph_o = n32 * ORBIT_STEP;
      ph_t = n32 * TONE_STEP;
      case (look_ff)
         3'd0:    look_addr = az_ff;
         3'd1:    look_addr = ao_ff + A'(TABLE_QUARTER);
         3'd2:    look_addr = ao_ff;
         3'd3:    look_addr = at_ff;
         default: look_addr = at_ff + A'(TABLE_QUARTER);
      endcase
      look_val = sine_lookup(look_addr);
      zoom_sum = C21 + (prod_ff >>> 30);
      div_num  = (state_ff == F_DSTI) ? (NUM_W'(cost_ff) <<< DIV_SHIFT)
                                      : (NUM_W'(sint_ff) <<< DIV_SHIFT);

      state_in  = state_ff;
      look_in   = look_ff;
      az_in     = az_ff;
      ao_in     = ao_ff;
      at_in     = at_ff;
      sinz_in   = sinz_ff;
      coso_in   = coso_ff;
      sino_in   = sino_ff;
      sint_in   = sint_ff;
      cost_in   = cost_ff;
      prod_in   = prod_ff;
      zoom_in   = zoom_ff;
      pt_in     = pt_ff;
      req.ready = 1'b0;
      div_start = 1'b0;
      push      = 1'b0;
      case (state_ff)
         F_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               az_in    = ph_z[31 -: A];
               ao_in    = ph_o[31 -: A];
               at_in    = ph_t[31 -: A];
               look_in  = 3'd0;
               state_in = F_LOOK;
            end
         end
         F_LOOK: begin
            case (look_ff)
               3'd0:    sinz_in = look_val;
               3'd1:    coso_in = look_val;
               3'd2:    sino_in = look_val;
               3'd3:    sint_in = look_val;
               default: cost_in = look_val;
            endcase
            look_in = look_ff + 3'd1;
            if (look_ff == 3'd4) begin
               state_in = F_ZMUL;
            end
         end
         F_ZMUL: begin
            prod_in  = C19 * 64'(sinz_ff);
            state_in = F_ZOOM;
         end
         F_ZOOM: begin
            zoom_in  = (zoom_sum <= 64'sd0) ? ONE_F[31:0] : zoom_sum[31:0];
            state_in = F_DSTR;
         end
         F_DSTR: begin
            div_start = 1'b1;
            state_in  = F_DWR;
         end
         F_DWR: begin
            if (div_stat.done) begin
               pt_in.zr = sat32(64'(coso_ff >>> ORBIT_SHIFT) + 64'(div_quo));
               state_in = F_DSTI;
            end
         end
         F_DSTI: begin
            div_start = 1'b1;
            state_in  = F_DWI;
         end
         F_DWI: begin
            if (div_stat.done) begin
               pt_in.zi = sat32(64'(sino_ff >>> ORBIT_SHIFT) + 64'(div_quo));
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign push_data = pt_ff;

   `JESC_ASSERT_NEVER(a_div_restart, clock, reset, div_start && div_stat.busy,
      "divider started while busy")

endmodule

>>> src/jesc_fifo.sv
// Short queue of start points between front end and iteration engine.
`timescale 1ns / 1ps
`include "julia_escape_audio_sample_assert.svh"
module jesc_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jesc_pkg::coord_type push_data,
   output logic                full,
   input  logic                pop,
   output jesc_pkg::coord_type pop_data,
   output logic                empty
);
   import jesc_pkg::*;

   coord_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   assign full     = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = entry_ff[rd_ff];

   `JESC_ASSERT_NEVER(a_push_full, clock, reset, push && full, "push into full queue")
   `JESC_ASSERT_NEVER(a_pop_empty, clock, reset, pop && empty, "pop from empty queue")

endmodule

>>> src/jesc_iter.sv
// Iteration engine: z = z^2 + c, one step a cycle, then maps the count to audio.
`timescale 1ns / 1ps
`include "julia_escape_audio_sample_assert.svh"
module jesc_iter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               empty,
   input  jesc_pkg::coord_type                pop_data,
   output logic                               pop,
   input  logic signed [jesc_pkg::COORD_W-1:0] c_real,
   input  logic signed [jesc_pkg::COORD_W-1:0] c_imag,
   jesc_rsp_if.source                         rsp
);
   import jesc_pkg::*;

   back_state_type state_ff, state_in;
   logic signed [31:0]      zr_ff, zr_in, zi_ff, zi_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic signed [AUDIO_W-1:0] fq_ff, fq_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic                    vld_ff, vld_in;
   logic signed [AUDIO_W-1:0] audio_ff, audio_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic signed [63:0]      rr, ii, ri;
   logic [63:0]             mag2;
   logic                    escaped;
   logic [REM_W:0]          rem_sum;
   logic                    wrap;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         vld_ff   <= 1'b0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         iter_ff  <= iter_in;
      end
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      fq_ff    <= fq_in;
      rem_ff   <= rem_in;
      audio_ff <= audio_in;
      count_ff <= count_in;
   end

   always_comb begin
      rr      = zr_ff * zr_ff;
      ii      = zi_ff * zi_ff;
      ri      = zr_ff * zi_ff;
      mag2    = rr + ii;
      escaped = |mag2[63:ESCAPE_BIT];
      rem_sum = {1'b0, rem_ff} + (REM_W + 1)'(AUDIO_STEP_R);
      wrap    = rem_sum >= (REM_W + 1)'(ITERATION_LIMIT);

      state_in = state_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      iter_in  = iter_ff;
      fq_in    = fq_ff;
      rem_in   = rem_ff;
      vld_in   = vld_ff && !rsp.ready;
      audio_in = audio_ff;
      count_in = count_ff;
      pop      = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               zr_in    = pop_data.zr;
               zi_in    = pop_data.zi;
               iter_in  = '0;
               fq_in    = -AUDIO_W'(AUDIO_OFFSET);
               rem_in   = '0;
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            if (iter_ff == ITER_W'(ITERATION_LIMIT) || escaped) begin
               state_in = B_DONE;
            end else begin
               zr_in   = sat32(((rr - ii) >>> COORD_FRAC_BITS) + 64'(c_real));
               zi_in   = sat32((ri >>> (COORD_FRAC_BITS - 1)) + 64'(c_imag));
               iter_in = iter_ff + 1'b1;
               rem_in  = wrap ? REM_W'(rem_sum - (REM_W + 1)'(ITERATION_LIMIT))
                              : rem_sum[REM_W-1:0];
               fq_in   = fq_ff + AUDIO_W'(AUDIO_STEP_Q) + AUDIO_W'(wrap);
            end
         end
         B_DONE: begin
            if (!vld_ff || rsp.ready) begin
               vld_in   = 1'b1;
               // floor quotient to truncation toward zero
               audio_in = (fq_ff < 0 && rem_ff != '0) ? fq_ff + 1'b1 : fq_ff;
               count_in = COUNT_W'(iter_ff);
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp.valid           = vld_ff;
   assign rsp.audio_sample    = audio_ff;
   assign rsp.iteration_count = count_ff;

   `JESC_ASSERT(a_iter_bound, clock, reset,
      iter_ff <= ITER_W'(ITERATION_LIMIT), "iteration count past limit")

endmodule

>>> src/julia_escape_audio_sample.sv
// Top level: Julia-set escape-time audio sample generator.
//
// req_ch carries a 48-bit sample number; rsp_ch returns one item per request
// with the signed 16-bit audio sample and the 9-bit iteration count; csr_ch
// writes the Julia constant (index 0 real, index 1 imaginary, signed Q4.28),
// always ready, to be written while no item is in flight.
// The front end takes an item, reads five table values, forms the zoom and
// divides twice by it with a bit-serial divider. A two-entry queue hands the
// start point to the iteration engine, which does one z = z^2 + c step a
// cycle. The slower of the two sets the sustained rate; each works on its own
// item meanwhile. Each item passes through the front end, the queue and the
// engine in turn.
// Reset clears all control state and loads c = -1.0 + 0i. When the receiver
// stalls, the result holds in the output register, the engine waits with the
// next finished item, and the queue and then req_ch.ready back up in turn.
`timescale 1ns / 1ps
module julia_escape_audio_sample (
   input  logic      clock,
   input  logic      reset,
   jesc_req_if.sink  req_ch,
   jesc_rsp_if.source rsp_ch,
   jesc_csr_if.sink  csr_ch
);
   import jesc_pkg::*;

   logic signed [COORD_W-1:0] c_real_ff, c_real_in, c_imag_ff, c_imag_in;
   logic      push, full, pop, empty;
   coord_type push_data, pop_data;

   always_comb begin
      c_real_in    = c_real_ff;
      c_imag_in    = c_imag_ff;
      csr_ch.ready = 1'b1;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_C_REAL: c_real_in = csr_ch.data;
            CSR_C_IMAG: c_imag_in = csr_ch.data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff <= -ONE_F[COORD_W-1:0];
         c_imag_ff <= '0;
      end else begin
         c_real_ff <= c_real_in;
         c_imag_ff <= c_imag_in;
      end
   end

   jesc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   jesc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   jesc_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .pop_data (pop_data),
      .pop      (pop),
      .c_real   (c_real_ff),
      .c_imag   (c_imag_ff),
      .rsp      (rsp_ch)
   );

endmodule

>>> tb/tb.sv
// Testbench for julia_escape_audio_sample: directed and random sample streams checked against a local predictor.
`timescale 1ns / 1ps
module tb;
   import jesc_pkg::*;

   localparam int          TAB_BITS   = 10;
   localparam int          TAB_SIZE   = 1 << TAB_BITS;
   localparam int          TAB_QTR    = TAB_SIZE / 4;
   localparam int          FRAC       = 28;
   localparam int          LIMIT      = 256;
   localparam logic [63:0] HALF_PI    = 64'd1686629713;
   localparam logic [63:0] UNIT_Q30   = 64'd1073741824;
   localparam longint      ESCAPE_SQ  = 64'sd4 <<< (2 * FRAC);
   localparam int          MAX_WAIT   = 14;

   typedef struct {
      logic [47:0]        n;
      logic signed [15:0] audio;
      logic [8:0]         count;
   } audio_expect_t;

   logic clock;
   logic reset;

   jesc_req_if req_if ();
   jesc_rsp_if rsp_if ();
   jesc_csr_if csr_if ();

   julia_escape_audio_sample DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   int            sine_q30 [TAB_SIZE];
   longint        c_real_now;
   longint        c_imag_now;
   logic [47:0]   pending_samples [$];
   audio_expect_t expected_audio [$];
   int            fail_count;
   int            items_checked;
   int            limit_hits;
   bit            quiet;
   bit            req_taken;
   bit            rsp_taken;
   int            req_gap;
   int            rsp_wait;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [63:0] quarter_wave(input int unsigned j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] div [6];
      div = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      x  = (HALF_PI * 64'(j)) / 64'(TAB_QTR);
      x2 = (x * x) >> 30;
      t  = UNIT_Q30;
      for (int k = 0; k < 6; k++) begin
         t = UNIT_Q30 - (((x2 * t) >> 30) / div[k]);
      end
      return (x * t) >> 30;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic audio_expect_t julia_predict(input logic [47:0] n);
      audio_expect_t r;
      logic [31:0]   ph_zoom;
      logic [31:0]   ph_orbit;
      logic [31:0]   ph_tone;
      logic [9:0]    a;
      longint        c21;
      longint        c19;
      longint        zoom;
      longint        zr;
      longint        zi;
      longint        rr;
      longint        ii;
      longint        nr;
      longint        ni;
      longint        smp;
      logic [63:0]   mag2;
      int            iter;
      c21      = ((64'sd21 <<< FRAC) + 64'sd5) / 64'sd10;
      c19      = ((64'sd19 <<< FRAC) + 64'sd5) / 64'sd10;
      ph_zoom  = 32'(64'(n) * 64'd354);
      ph_orbit = 32'(64'(n) * 64'd89);
      ph_tone  = 32'(64'(n) * 64'd2447909);
      zoom = c21 + ((c19 * longint'(sine_q30[ph_zoom[31:22]])) >>> 30);
      if (zoom <= 0) zoom = 64'sd1 <<< FRAC;
      a  = ph_orbit[31:22] + 10'd256;
      zr = (longint'(sine_q30[a]) >>> (31 - FRAC))
         + (longint'(sine_q30[ph_tone[31:22]]) * (64'sd1 <<< (2 * FRAC - 30))) / zoom;
      a  = ph_tone[31:22] + 10'd256;
      zi = (longint'(sine_q30[ph_orbit[31:22]]) >>> (31 - FRAC))
         + (longint'(sine_q30[a]) * (64'sd1 <<< (2 * FRAC - 30))) / zoom;
      zr = clamp32(zr);
      zi = clamp32(zi);
      iter = 0;
      while (iter < LIMIT) begin
         rr = zr * zr;
         ii = zi * zi;
         // both squares at the negative rail sum to 2^63: compare unsigned
         mag2 = rr + ii;
         if (mag2 >= 64'(ESCAPE_SQ)) break;
         nr = ((rr - ii) >>> FRAC) + c_real_now;
         ni = ((zr * zi) >>> (FRAC - 1)) + c_imag_now;
         zr = clamp32(nr);
         zi = clamp32(ni);
         iter++;
      end
      smp     = (longint'(iter) * 56000 - 64'sd28000 * LIMIT) / LIMIT;
      r.n     = n;
      r.audio = 16'(smp);
      r.count = 9'(iter);
      return r;
   endfunction

   // sample driver
   always @(negedge clock) begin
      logic v_next;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         v_next = req_if.valid;
         if (req_taken) begin
            v_next  = 1'b0;
            req_gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (!v_next) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_samples.size() > 0) begin
               req_if.sample_number <= pending_samples.pop_front();
               v_next = 1'b1;
            end
         end
         req_if.valid <= v_next;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_taken) rsp_wait = quiet ? 0 : $urandom_range(0, MAX_WAIT);
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // accept side: predict; result side: compare
   always @(posedge clock) begin
      audio_expect_t e;
      req_taken <= !reset && req_if.valid && req_if.ready;
      rsp_taken <= !reset && rsp_if.valid && rsp_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         expected_audio.push_back(julia_predict(req_if.sample_number));
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_audio.size() == 0) begin
            $error("unexpected item: audio_sample %0d iteration_count %0d",
                   rsp_if.audio_sample, rsp_if.iteration_count);
            fail_count++;
         end else begin
            e = expected_audio.pop_front();
            items_checked++;
            if (e.count == 9'(LIMIT)) limit_hits++;
            if (rsp_if.audio_sample !== e.audio) begin
               $error("audio_sample (n=%0d): expected %0d, actual %0d",
                      e.n, e.audio, rsp_if.audio_sample);
               fail_count++;
            end
            if (rsp_if.iteration_count !== e.count) begin
               $error("iteration_count (n=%0d): expected %0d, actual %0d",
                      e.n, e.count, rsp_if.iteration_count);
               fail_count++;
            end
         end
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == CSR_C_REAL) c_real_now = longint'($signed(value));
      else c_imag_now = longint'($signed(value));
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_samples.size() > 0 || expected_audio.size() > 0 || req_if.valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [47:0] random_sample();
      logic [47:0] n;
      case ($urandom_range(0, 3))
         0: n = {$urandom, $urandom};
         1: n = 48'($urandom_range(0, 100000));
         2: n = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 5000));
         default: n = 48'(32'd9099507 + $urandom_range(0, 400000)) - 48'd200000;
      endcase
      return n;
   endfunction

   // mostly short consecutive runs, as an audio stream would send them
   task automatic random_phase(input logic [31:0] cr, input logic [31:0] ci, input int count);
      logic [47:0] base;
      int          run;
      csr_write(CSR_C_REAL, cr);
      csr_write(CSR_C_IMAG, ci);
      quiet = ($urandom_range(0, 3) == 0);
      while (count > 0) begin
         base = random_sample();
         run  = $urandom_range(1, 12);
         for (int k = 0; k < run && count > 0; k++) begin
            pending_samples.push_back(base + 48'(k));
            count--;
         end
      end
      drain();
   endtask

   initial begin
      logic [63:0] mag;
      int          quad;
      int          j;
      for (int k = 0; k < TAB_SIZE; k++) begin
         quad = k / TAB_QTR;
         j    = k % TAB_QTR;
         mag  = quad[0] ? quarter_wave(TAB_QTR - j) : quarter_wave(j);
         sine_q30[k] = quad[1] ? -int'(mag) : int'(mag);
      end
      c_real_now    = -(64'sd1 <<< FRAC);
      c_imag_now    = 0;
      fail_count    = 0;
      items_checked = 0;
      limit_hits    = 0;
      quiet         = 1'b0;
      req_taken     = 1'b0;
      rsp_taken     = 1'b0;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.sample_number = '0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.index         = CSR_C_REAL;
      csr_if.data          = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, alternating bits, zoom near its minimum and maximum
      foreach (pending_samples[i]) ;
      pending_samples = '{48'd0, 48'd1, 48'd2, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000,
                          48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h0000_FFFF_FFFF,
                          48'h0001_0000_0000, 48'd9099507, 48'd9099506, 48'd9100000,
                          48'd3033169, 48'd6066338, 48'd12132676, 48'd48258059,
                          48'd1754, 48'd877, 48'd386000, 48'd193000};
      drain();
      // c = 0: start points inside the unit circle never escape
      random_phase(32'h0000_0000, 32'h0000_0000, 40);
      random_phase(32'hF000_0000, 32'h0000_0000, 400);
      random_phase(32'hF333_3333, 32'h027E_F9DB, 400);
      random_phase(32'h8000_0000, 32'h8000_0000, 120);
      random_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 120);
      random_phase(32'h0000_0000, 32'h0000_0000, 60);
      random_phase(32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000),
                   32'($signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000), 450);

      repeat (600) @(posedge clock);
      if (expected_audio.size() > 0) begin
         $error("%0d expected items never arrived", expected_audio.size());
         fail_count++;
      end
      $display("Checked %0d audio items over 8 Julia constants, %0d reached the iteration limit.",
               items_checked, limit_hits);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
